@@ hw/rtl/pmfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged monochrome framebuffer package
// Shared types and panel geometry for the framebuffer and its frame store.
// ----------------------------------------------------------------------------
package pmfb_pkg;

   // Panel geometry. Each column holds one byte per eight-row page.
   localparam int PANEL_WIDTH  = 96;
   localparam int PANEL_HEIGHT = 65;
   localparam int PAGES        = PANEL_HEIGHT / 8 + 1;
   localparam int STORE_DEPTH  = PANEL_WIDTH * PAGES;

   localparam int X_W    = $clog2(PANEL_WIDTH);
   localparam int Y_W    = $clog2(PANEL_HEIGHT);
   localparam int PAGE_W = 4;
   localparam int ADDR_W = $clog2(STORE_DEPTH);

   // Controller command bases.
   localparam logic [7:0] CMD_PAGE   = 8'hB0;
   localparam logic [7:0] CMD_COL_LO = 8'h00;
   localparam logic [7:0] CMD_COL_HI = 8'h10;

   typedef enum logic [1:0] {
      MODE_DRAW  = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_FLUSH = 2'd2,
      MODE_TICK  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      COLOR_SET    = 2'd0,
      COLOR_CLEAR  = 2'd1,
      COLOR_INVERT = 2'd2,
      COLOR_KEEP   = 2'd3
   } color_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      color_type          color;
   } req_type;

   typedef struct packed {
      logic       is_data;
      logic [7:0] word_byte;
      logic       last;
   } rsp_type;

endpackage

@@ hw/rtl/paged_mono_framebuffer_dirty_flush_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged monochrome framebuffer with dirty-rectangle flush
// Frame store of column bytes in eight-row pages, pixel drawing with rotation,
// a dirty rectangle and a sequencer that streams the dirty area to a panel
// controller one word per tick request.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Carries
//   req_     in         req_valid/req_ready  mode, pos_x, pos_y, color
//   rsp_     out        rsp_valid/rsp_ready  is_data, word_byte, last
//   csr_     in         csr_wr_en            rotation (2 bits)
//
// A draw request that lands on the panel passes through accept, a frame
// store read and a write back; one that misses is only accepted. A flush
// start or a tick that emits a command is done at accept; a tick that emits
// a data byte adds a state for the registered frame store read. A clear request
// starts a sweep over all PANEL_WIDTH*PAGES (864) store addresses that zeroes
// the store. After reset the same sweep runs before req_ready rises.
// A request is only taken while the result register is empty or being
// drained, so a stalled rsp_ channel holds off further requests.
//
module paged_mono_framebuffer_dirty_flush_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pmfb_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pmfb_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data
);
   import pmfb_pkg::*;

   // Control sequencer: sweep, wait for requests, draw read/write, data read.
   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_DRAW_RD,
      S_DRAW_WR,
      S_DATA_RD
   } state_type;

   // Flush sequencer phase.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PAGE,
      PH_COL_LO,
      PH_COL_HI,
      PH_DATA,
      PH_FINAL
   } phase_type;

   localparam logic [X_W-1:0]    X_MAX     = X_W'(PANEL_WIDTH - 1);
   localparam logic [Y_W-1:0]    Y_MAX     = Y_W'(PANEL_HEIGHT - 1);
   localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] ADDR_STEP = ADDR_W'(PAGES);
   localparam logic [14:0]       LIM_W     = 15'(PANEL_WIDTH);
   localparam logic [14:0]       LIM_H     = 15'(PANEL_HEIGHT);

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [1:0]        rotation_ff, rotation_in;
   logic [X_W-1:0]    x_low_ff, x_low_in, x_high_ff, x_high_in;
   logic [Y_W-1:0]    y_low_ff, y_low_in, y_high_ff, y_high_in;
   logic [PAGE_W-1:0] page_ff, page_in, end_page_ff, end_page_in;
   logic [X_W-1:0]    column_ff, column_in;
   logic [ADDR_W-1:0] flush_addr_ff, flush_addr_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Draw payload held across the read-modify-write.
   logic [X_W-1:0]    px_ff, px_in;
   logic [Y_W-1:0]    py_ff, py_in;
   color_type         color_ff, color_in;
   logic [ADDR_W-1:0] draw_addr_ff, draw_addr_in;

   logic              accept;
   logic              on_panel;
   logic [X_W-1:0]    rot_px;
   logic [Y_W-1:0]    rot_py;
   logic [14:0]       lim_x, lim_y;
   logic [PAGE_W-1:0] first_page, last_page;
   logic [7:0]        bit_mask, new_byte;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]        ram_wr_data, ram_rd_data;

   pmfb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready   = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Bounds check in logical coordinates; odd rotations swap width and height.
   assign lim_x    = rotation_ff[0] ? LIM_H : LIM_W;
   assign lim_y    = rotation_ff[0] ? LIM_W : LIM_H;
   assign on_panel = !req_payload.pos_x[15] && (req_payload.pos_x[14:0] < lim_x) &&
                     !req_payload.pos_y[15] && (req_payload.pos_y[14:0] < lim_y);

   // Quarter-turn mapping onto panel coordinates. Inside the bounds every
   // coordinate fits the narrow slices taken here.
   always_comb begin
      case (rotation_ff)
         2'd1: begin
            rot_px = req_payload.pos_y[X_W-1:0];
            rot_py = Y_MAX - req_payload.pos_x[Y_W-1:0];
         end
         2'd2: begin
            rot_px = X_MAX - req_payload.pos_x[X_W-1:0];
            rot_py = Y_MAX - req_payload.pos_y[Y_W-1:0];
         end
         2'd3: begin
            rot_px = X_MAX - req_payload.pos_y[X_W-1:0];
            rot_py = req_payload.pos_x[Y_W-1:0];
         end
         default: begin
            rot_px = req_payload.pos_x[X_W-1:0];
            rot_py = req_payload.pos_y[Y_W-1:0];
         end
      endcase
   end

   // Page range of the dirty rectangle, clamped to the last page.
   assign first_page = PAGE_W'(y_low_ff >> 3);
   assign last_page  = (PAGE_W'(y_high_ff >> 3) > PAGE_LAST) ? PAGE_LAST
                                                              : PAGE_W'(y_high_ff >> 3);

   // Bit update for the pixel being drawn.
   assign bit_mask = 8'd1 << py_ff[2:0];
   always_comb begin
      case (color_ff)
         COLOR_SET:    new_byte = ram_rd_data | bit_mask;
         COLOR_CLEAR:  new_byte = ram_rd_data & ~bit_mask;
         COLOR_INVERT: new_byte = ram_rd_data ^ bit_mask;
         default:      new_byte = ram_rd_data;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      rotation_in   = csr_wr_en ? csr_wr_data : rotation_ff;
      x_low_in      = x_low_ff;
      x_high_in     = x_high_ff;
      y_low_in      = y_low_ff;
      y_high_in     = y_high_ff;
      page_in       = page_ff;
      end_page_in   = end_page_ff;
      column_in     = column_ff;
      flush_addr_in = flush_addr_ff;
      sweep_addr_in = sweep_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      color_in      = color_ff;
      draw_addr_in  = draw_addr_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = sweep_addr_ff;
      ram_wr_data   = 8'd0;
      ram_rd_addr   = flush_addr_ff;

      case (state_ff)
         S_SWEEP: begin
            ram_wr_en     = 1'b1;
            sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            if (sweep_addr_ff == ADDR_LAST) begin
               sweep_addr_in = '0;
               state_in      = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_payload.mode)
                  MODE_DRAW: begin
                     px_in    = rot_px;
                     py_in    = rot_py;
                     color_in = req_payload.color;
                     if (phase_ff == PH_IDLE && on_panel) begin
                        state_in = S_DRAW_RD;
                     end
                  end
                  MODE_CLEAR: begin
                     if (phase_ff == PH_IDLE) begin
                        x_low_in  = '0;
                        x_high_in = X_MAX;
                        y_low_in  = '0;
                        y_high_in = Y_MAX;
                        state_in  = S_SWEEP;
                     end
                  end
                  MODE_FLUSH: begin
                     if (phase_ff == PH_IDLE) begin
                        if (x_low_ff > x_high_ff || y_low_ff > y_high_ff ||
                            first_page > last_page) begin
                           phase_in = PH_FINAL;
                        end else begin
                           page_in     = first_page;
                           end_page_in = last_page;
                           column_in   = x_low_ff;
                           phase_in    = PH_PAGE;
                        end
                     end
                  end
                  default: begin
                     // Tick: one controller word per request, none while the flush sequencer is idle.
                     rsp_data_in.is_data   = 1'b0;
                     rsp_data_in.last      = 1'b0;
                     rsp_data_in.word_byte = 8'd0;
                     case (phase_ff)
                        PH_PAGE: begin
                           rsp_valid_in          = 1'b1;
                           rsp_data_in.word_byte = CMD_PAGE | 8'(page_ff);
                           phase_in              = PH_COL_LO;
                        end
                        PH_COL_LO: begin
                           rsp_valid_in          = 1'b1;
                           rsp_data_in.word_byte = CMD_COL_LO | 8'(x_low_ff[3:0]);
                           phase_in              = PH_COL_HI;
                        end
                        PH_COL_HI: begin
                           rsp_valid_in          = 1'b1;
                           rsp_data_in.word_byte = CMD_COL_HI | 8'(3'(x_low_ff >> 4));
                           column_in             = x_low_ff;
                           flush_addr_in         = ADDR_W'(x_low_ff) * ADDR_STEP
                                                   + ADDR_W'(page_ff);
                           phase_in              = PH_DATA;
                        end
                        PH_DATA: begin
                           // Byte arrives from the store next cycle.
                           state_in = S_DATA_RD;
                           if (column_ff >= x_high_ff) begin
                              if (page_ff < end_page_ff) begin
                                 page_in  = page_ff + PAGE_W'(1);
                                 phase_in = PH_PAGE;
                              end else begin
                                 phase_in = PH_FINAL;
                              end
                           end else begin
                              column_in     = column_ff + X_W'(1);
                              flush_addr_in = flush_addr_ff + ADDR_STEP;
                           end
                        end
                        PH_FINAL: begin
                           rsp_valid_in          = 1'b1;
                           rsp_data_in.word_byte = CMD_PAGE;
                           rsp_data_in.last      = 1'b1;
                           x_low_in              = X_MAX;
                           x_high_in             = '0;
                           y_low_in              = Y_MAX;
                           y_high_in             = '0;
                           page_in               = '0;
                           column_in             = '0;
                           phase_in              = PH_IDLE;
                        end
                        default: begin
                           phase_in = PH_IDLE;
                        end
                     endcase
                  end
               endcase
            end
         end
         S_DRAW_RD: begin
            draw_addr_in = ADDR_W'(px_ff) * ADDR_STEP + ADDR_W'(py_ff >> 3);
            ram_rd_addr  = draw_addr_in;
            state_in     = S_DRAW_WR;
         end
         S_DRAW_WR: begin
            ram_wr_en   = (color_ff != COLOR_KEEP);
            ram_wr_addr = draw_addr_ff;
            ram_wr_data = new_byte;
            if (px_ff < x_low_ff)  x_low_in  = px_ff;
            if (px_ff > x_high_ff) x_high_in = px_ff;
            if (py_ff < y_low_ff)  y_low_in  = py_ff;
            if (py_ff > y_high_ff) y_high_in = py_ff;
            state_in = S_IDLE;
         end
         S_DATA_RD: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.is_data   = 1'b1;
            rsp_data_in.word_byte = ram_rd_data;
            rsp_data_in.last      = 1'b0;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         phase_ff      <= PH_IDLE;
         rotation_ff   <= 2'd0;
         x_low_ff      <= '0;
         x_high_ff     <= '0;
         y_low_ff      <= '0;
         y_high_ff     <= '0;
         page_ff       <= '0;
         end_page_ff   <= '0;
         column_ff     <= '0;
         flush_addr_ff <= '0;
         sweep_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         rotation_ff   <= rotation_in;
         x_low_ff      <= x_low_in;
         x_high_ff     <= x_high_in;
         y_low_ff      <= y_low_in;
         y_high_ff     <= y_high_in;
         page_ff       <= page_in;
         end_page_ff   <= end_page_in;
         column_ff     <= column_in;
         flush_addr_ff <= flush_addr_in;
         sweep_addr_ff <= sweep_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      color_ff     <= color_in;
      draw_addr_ff <= draw_addr_in;
   end

endmodule

@@ hw/rtl/pmfb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pmfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/paged_mono_framebuffer_dirty_flush_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged monochrome framebuffer testbench
// Drives draw, clear, flush and tick requests into the framebuffer, mirrors
// the frame store, dirty rectangle and flush sequencer in a local model, and
// checks every controller word that comes out against that model.
// ----------------------------------------------------------------------------
module paged_mono_framebuffer_dirty_flush_top_tb;
   import pmfb_pkg::*;

   // A rotation change waits longer than a clear sweep lasts, so that no
   // sweep can still be running when the register moves.
   localparam int SWEEP_WAIT  = 900;
   // The longest quiet stretch in a correct run is one rotation pause plus
   // one clear sweep plus the drawn idle gaps on each side.
   localparam int STALL_LIMIT = 10000;
   localparam int PHASE_ITEMS = 170;

   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // Steps of the flush sequencer as the model tracks them.
   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_PAGE,
      STEP_COL_LO,
      STEP_COL_HI,
      STEP_DATA,
      STEP_CLOSE
   } flush_step_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic    csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = 2'd0;

   paged_mono_framebuffer_dirty_flush_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Model of the framebuffer. It is advanced once per accepted request, at
   // the clock edge of the handshake, so that the generator can look at it
   // after waiting for the request queue to drain.
   // ------------------------------------------------------------------------
   logic [7:0]     pixel_bytes [STORE_DEPTH];
   int             dx_lo = 0, dx_hi = 0, dy_lo = 0, dy_hi = 0;
   int             fl_page = 0, fl_col = 0, fl_end = 0;
   flush_step_type step = STEP_IDLE;
   logic [1:0]     rot = ROT_0;

   // Controller words that the model says are still to come, oldest first.
   rsp_type     panel_words [$];
   int          words_pending = 0;

   req_type     pending_reqs [$];
   int          req_total = 0;
   int          req_done = 0;
   int          req_gap = 0;
   int          rsp_hold = 0;
   bit          no_idle = 1'b0;
   int          mismatch_count = 0;
   int          stall_cycles = 0;

   function automatic void widen(input int xl, input int yl, input int xh, input int yh);
      if (xl < dx_lo) dx_lo = xl;
      if (xh > dx_hi) dx_hi = xh;
      if (yl < dy_lo) dy_lo = yl;
      if (yh > dy_hi) dy_hi = yh;
   endfunction

   // Number of ticks that the running flush still needs, the closing
   // command included. The rectangle cannot change while a flush runs.
   function automatic int words_left();
      int per_page;
      per_page = 3 + dx_hi - dx_lo + 1;
      case (step)
         STEP_IDLE:   return 0;
         STEP_CLOSE:  return 1;
         STEP_PAGE:   return (fl_end - fl_page + 1) * per_page + 1;
         STEP_COL_LO: return (fl_end - fl_page + 1) * per_page;
         STEP_COL_HI: return (fl_end - fl_page + 1) * per_page - 1;
         default:     return (dx_hi - fl_col + 1) + (fl_end - fl_page) * per_page + 1;
      endcase
   endfunction

   task automatic apply_request(input req_type r);
      int      x, y, lw, lh, px, py, idx, first;
      rsp_type w;
      logic    emit;
      emit = 1'b0;
      w = '0;
      case (r.mode)
         MODE_DRAW: begin
            // Draws are dropped while a flush runs and when off the panel.
            x  = r.pos_x;
            y  = r.pos_y;
            lw = rot[0] ? PANEL_HEIGHT : PANEL_WIDTH;
            lh = rot[0] ? PANEL_WIDTH : PANEL_HEIGHT;
            if (step == STEP_IDLE && x >= 0 && x < lw && y >= 0 && y < lh) begin
               case (rot)
                  ROT_90: begin
                     px = y;
                     py = PANEL_HEIGHT - 1 - x;
                  end
                  ROT_180: begin
                     px = PANEL_WIDTH - 1 - x;
                     py = PANEL_HEIGHT - 1 - y;
                  end
                  ROT_270: begin
                     px = PANEL_WIDTH - 1 - y;
                     py = x;
                  end
                  default: begin
                     px = x;
                     py = y;
                  end
               endcase
               idx = px * PAGES + py / 8;
               case (r.color)
                  COLOR_SET:    pixel_bytes[idx][py % 8] = 1'b1;
                  COLOR_CLEAR:  pixel_bytes[idx][py % 8] = 1'b0;
                  COLOR_INVERT: pixel_bytes[idx][py % 8] = ~pixel_bytes[idx][py % 8];
                  default: ;
               endcase
               // Even a kept byte widens the dirty rectangle.
               widen(px, py, px, py);
            end
         end
         MODE_CLEAR: begin
            if (step == STEP_IDLE) begin
               foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
               widen(0, 0, PANEL_WIDTH - 1, PANEL_HEIGHT - 1);
            end
         end
         MODE_FLUSH: begin
            // An empty rectangle skips straight to the closing command.
            if (step == STEP_IDLE) begin
               if (dx_lo > dx_hi || dy_lo > dy_hi) begin
                  step = STEP_CLOSE;
               end else begin
                  first  = dy_lo / 8;
                  fl_end = dy_hi / 8;
                  if (fl_end > PAGES - 1) fl_end = PAGES - 1;
                  if (first > fl_end) begin
                     step = STEP_CLOSE;
                  end else begin
                     fl_page = first;
                     fl_col  = dx_lo;
                     step    = STEP_PAGE;
                  end
               end
            end
         end
         default: begin
            // A tick emits one word unless the sequencer is idle.
            emit = 1'b1;
            case (step)
               STEP_PAGE: begin
                  w.word_byte = CMD_PAGE | {4'h0, fl_page[3:0]};
                  step = STEP_COL_LO;
               end
               STEP_COL_LO: begin
                  w.word_byte = CMD_COL_LO | {4'h0, dx_lo[3:0]};
                  step = STEP_COL_HI;
               end
               STEP_COL_HI: begin
                  w.word_byte = CMD_COL_HI | {5'h00, dx_lo[6:4]};
                  fl_col = dx_lo;
                  step = STEP_DATA;
               end
               STEP_DATA: begin
                  w.is_data = 1'b1;
                  if (fl_col < PANEL_WIDTH && fl_page < PAGES)
                     w.word_byte = pixel_bytes[fl_col * PAGES + fl_page];
                  if (fl_col >= dx_hi) begin
                     if (fl_page < fl_end) begin
                        fl_page = (fl_page + 1) % 16;
                        step = STEP_PAGE;
                     end else begin
                        step = STEP_CLOSE;
                     end
                  end else begin
                     fl_col = (fl_col + 1) % 128;
                  end
               end
               STEP_CLOSE: begin
                  // Closing page-0 command; the rectangle goes back to empty.
                  w.word_byte = CMD_PAGE;
                  w.last = 1'b1;
                  dx_lo = PANEL_WIDTH - 1;
                  dx_hi = 0;
                  dy_lo = PANEL_HEIGHT - 1;
                  dy_hi = 0;
                  fl_page = 0;
                  fl_col = 0;
                  step = STEP_IDLE;
               end
               default: emit = 1'b0;
            endcase
         end
      endcase
      if (emit) begin
         panel_words.push_back(w);
         words_pending++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver. It holds a request until the handshake, then waits the
   // drawn number of idle cycles before presenting the next one. The model is
   // advanced here, at the accepting edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            apply_request(req_payload);
            req_done++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_payload <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_gap = no_idle ? 0 : $urandom_range(0, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor. Each accepted word is checked against the oldest
   // predicted word. After each word the ready line is held low for a drawn
   // number of cycles, which also backs up the request side.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (words_pending == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: is_data=%0d byte=%02h last=%0d",
                           rsp_payload.is_data, rsp_payload.word_byte, rsp_payload.last);
            end else begin
               want = panel_words.pop_front();
               words_pending--;
               if (rsp_payload.is_data !== want.is_data ||
                   rsp_payload.word_byte !== want.word_byte ||
                   rsp_payload.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("word mismatch: expected is_data=%0d byte=%02h last=%0d, %s%0d %s%02h %s%0d",
                              want.is_data, want.word_byte, want.last,
                              "got is_data=", rsp_payload.is_data,
                              "byte=", rsp_payload.word_byte,
                              "last=", rsp_payload.last);
               end
            end
            rsp_hold = no_idle ? 0 : $urandom_range(0, 7);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: a run that stops making progress on either channel fails.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus generation.
   // ------------------------------------------------------------------------
   task automatic send(input mode_type m, input int x, input int y, input color_type c);
      req_type r;
      r.mode  = m;
      r.pos_x = x[15:0];
      r.pos_y = y[15:0];
      r.color = c;
      pending_reqs.push_back(r);
      req_total++;
   endtask

   task automatic send_tick();
      send(MODE_TICK, $urandom, $urandom, color_type'($urandom_range(0, 3)));
   endtask

   task automatic drain();
      wait (req_done == req_total);
   endtask

   // Ticks a running flush through to its closing command.
   task automatic finish_flush();
      int n;
      drain();
      n = words_left();
      repeat (n) send_tick();
      drain();
   endtask

   // The rotation only moves while nothing is in flight and any clear sweep
   // has had time to end.
   task automatic write_rotation(input logic [1:0] value);
      drain();
      wait (words_pending == 0);
      repeat (SWEEP_WAIT) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rot = value;
   endtask

   // One well-formed sequence: an occasional clear, a few draws clustered around a
   // random point, with now and then an edge point, a wild coordinate or a stray
   // request, then a flush and the ticks that drain it. Sometimes the flush is cut
   // short, so that the next sequence runs into a flush still in progress.
   task automatic random_burst();
      int n, k, lw, lh, bx, by, x, y;
      lw = rot[0] ? PANEL_HEIGHT : PANEL_WIDTH;
      lh = rot[0] ? PANEL_WIDTH : PANEL_HEIGHT;
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0)
         send(MODE_CLEAR, $urandom, $urandom, color_type'($urandom_range(0, 3)));
      bx = $urandom_range(0, lw - 1);
      by = $urandom_range(0, lh - 1);
      n = $urandom_range(1, 10);
      repeat (n) begin
         k = $urandom_range(0, 19);
         if (k < 17) begin
            x = bx + $urandom_range(0, 7) - 3;
            y = by + $urandom_range(0, 7) - 3;
         end else if (k < 19) begin
            x = $urandom_range(0, lw + 1) - 1;
            y = $urandom_range(0, lh + 1) - 1;
         end else begin
            x = $urandom;
            y = $urandom;
         end
         send(MODE_DRAW, x, y, color_type'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 9) == 0)
         send(mode_type'($urandom_range(0, 3)), $urandom, $urandom,
              color_type'($urandom_range(0, 3)));
      send(MODE_FLUSH, $urandom, $urandom, color_type'($urandom_range(0, 3)));
      drain();
      n = words_left();
      if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
      else n = n + $urandom_range(0, 2);
      repeat (n) send_tick();
   endtask

   initial begin
      logic [1:0] rot_plan [6];
      int stop_at;

      foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
      rot_plan = '{ROT_270, ROT_90, ROT_180, ROT_0, 2'($urandom), 2'($urandom)};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_rotation(ROT_0);

      // A tick with no flush armed produces nothing.
      send(MODE_TICK, 0, 0, COLOR_SET);
      // Out of reset the rectangle covers pixel (0,0) only.
      send(MODE_FLUSH, 0, 0, COLOR_SET);
      finish_flush();
      // Right after a flush the rectangle is empty: only the closing command.
      send(MODE_FLUSH, 0, 0, COLOR_SET);
      finish_flush();

      // Corners, points just off each edge and the extreme coordinates.
      send(MODE_DRAW, 0, 0, COLOR_SET);
      send(MODE_DRAW, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, COLOR_SET);
      send(MODE_DRAW, -1, 0, COLOR_SET);
      send(MODE_DRAW, 0, -1, COLOR_SET);
      send(MODE_DRAW, PANEL_WIDTH, 0, COLOR_SET);
      send(MODE_DRAW, 0, PANEL_HEIGHT, COLOR_SET);
      send(MODE_DRAW, -32768, 32767, COLOR_SET);
      send(MODE_DRAW, 32767, -32768, COLOR_INVERT);
      send(MODE_DRAW, 5, 10, COLOR_INVERT);
      send(MODE_DRAW, 5, 10, COLOR_INVERT);
      send(MODE_DRAW, 6, 11, COLOR_SET);
      send(MODE_DRAW, 6, 11, COLOR_CLEAR);
      send(MODE_DRAW, 40, 30, COLOR_KEEP);
      send(MODE_FLUSH, 0, 0, COLOR_SET);
      drain();
      repeat (3) send_tick();
      // Draw, clear and a second start are all ignored mid-flush.
      send(MODE_DRAW, 1, 1, COLOR_SET);
      send(MODE_CLEAR, 0, 0, COLOR_SET);
      send(MODE_FLUSH, 0, 0, COLOR_SET);
      finish_flush();
      // A clear dirties the whole panel; flush it with one pixel set.
      send(MODE_CLEAR, 0, 0, COLOR_SET);
      send(MODE_DRAW, 3, 3, COLOR_SET);
      send(MODE_FLUSH, 0, 0, COLOR_SET);
      finish_flush();

      // Random sequences under each rotation, the extremes among them.
      foreach (rot_plan[p]) begin
         finish_flush();
         write_rotation(rot_plan[p]);
         stop_at = req_total + PHASE_ITEMS;
         while (req_total < stop_at) random_burst();
      end
      finish_flush();

      no_idle = 1'b0;
      wait (words_pending == 0);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
